FILE: sv/rbrt_pkg.sv
// Package for the reconnect backoff and report timer.
// Holds event codes, register indexes, widths, reset values and the config struct.
// No dependencies.
`timescale 1ns / 1ps

package rbrt_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W = 32;
	localparam int CMD_W = 2;
	localparam int DELAY_W = 32;
	localparam int FIRST_W = 16;
	localparam int SEC_W = 16;
	localparam int INTERVAL_W = 26;
	localparam int STEPS = 4;
	localparam int IDX_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	localparam logic [INTERVAL_W-1:0] MS_PER_SEC = INTERVAL_W'(1000);

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LINK_UP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LINK_DOWN = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REPORT_REQ = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_THIRD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_LAST = 3'd5;

	localparam logic [INTERVAL_W-1:0] RST_INTERVAL_MS = INTERVAL_W'(60000);
	localparam logic [FIRST_W-1:0] RST_FIRST_DELAY = FIRST_W'(1500);
	localparam logic [DELAY_W-1:0] RST_BACKOFF_FIRST = DELAY_W'(5000);
	localparam logic [DELAY_W-1:0] RST_BACKOFF_SECOND = DELAY_W'(10000);
	localparam logic [DELAY_W-1:0] RST_BACKOFF_THIRD = DELAY_W'(20000);
	localparam logic [DELAY_W-1:0] RST_BACKOFF_LAST = DELAY_W'(30000);

	typedef struct packed {
		logic [INTERVAL_W-1:0] interval_ms;
		logic [FIRST_W-1:0] first_delay_ms;
		logic [STEPS-1:0][DELAY_W-1:0] backoff_ms;
	} rbrt_cfg_t;

endpackage

FILE: sv/reconnect_backoff_report_timer_top.sv
// Top level of the reconnect backoff and report timer.
// Input register, result register and stream handshake around rbrt_cfg and rbrt_core.
// Depends on rbrt_pkg, rbrt_cfg and rbrt_core.
//
//   Channel  | Direction | Beat contents
//   ---------+-----------+------------------------------------------------
//   s_*      | in        | one event: command and millisecond timestamp
//   m_*      | out       | one result: start_connect, send_report, link_up
//   cfg_*    | in        | register write, no handshake, no read-back
//
// Every event beat yields exactly one result beat.
// One beat per cycle is sustained while m_tready stays high; the state update
// sits between the input register and the result register.
// A stalled result register holds the input register, and s_tready drops
// only when both are full. Reset restores the state and all register values.
`timescale 1ns / 1ps

module reconnect_backoff_report_timer_top #(
	parameter int TIME_BITS = rbrt_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [rbrt_pkg::S_TDATA_W-1:0] s_tdata, // command[1:0], now_ms[33:2], zeros
	output logic m_tvalid,
	input  logic m_tready,
	output logic [rbrt_pkg::M_TDATA_W-1:0] m_tdata, // start_connect, send_report, link_up, zeros
	input  logic cfg_we,
	input  logic [rbrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	rbrt_pkg::rbrt_cfg_t cfg;

	logic valid_s1;
	logic [rbrt_pkg::CMD_W-1:0] command_s1;
	logic [rbrt_pkg::NOW_W-1:0] now_s1;
	logic valid_s2;
	logic [2:0] result_s2;
	logic advance;
	logic step;
	logic start_connect, send_report, link_up;

	assign advance = !valid_s2 || m_tready;
	assign step = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tdata[rbrt_pkg::CMD_W-1:0];
			now_s1 <= s_tdata[rbrt_pkg::CMD_W +: rbrt_pkg::NOW_W];
		end
		if (step) begin
			result_s2 <= {link_up, send_report, start_connect};
		end
	end

	rbrt_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	rbrt_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.command(command_s1),
		.now_ms(now_s1),
		.cfg(cfg),
		.start_connect(start_connect),
		.send_report(send_report),
		.link_up(link_up)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(rbrt_pkg::M_TDATA_W - 3){1'b0}}, result_s2};

endmodule

FILE: sv/rbrt_cfg.sv
// Configuration registers of the reconnect backoff and report timer.
// The report interval is kept in milliseconds, scaled once at write time.
// Depends on rbrt_pkg.
`timescale 1ns / 1ps

module rbrt_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rbrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbrt_pkg::CFG_DATA_W-1:0] cfg_data,
	output rbrt_pkg::rbrt_cfg_t cfg
);

	rbrt_pkg::rbrt_cfg_t cfg_q;
	logic [rbrt_pkg::INTERVAL_W-1:0] interval_scaled;

	assign interval_scaled = rbrt_pkg::INTERVAL_W'(cfg_data[rbrt_pkg::SEC_W-1:0])
		* rbrt_pkg::MS_PER_SEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms <= rbrt_pkg::RST_INTERVAL_MS;
			cfg_q.first_delay_ms <= rbrt_pkg::RST_FIRST_DELAY;
			cfg_q.backoff_ms[0] <= rbrt_pkg::RST_BACKOFF_FIRST;
			cfg_q.backoff_ms[1] <= rbrt_pkg::RST_BACKOFF_SECOND;
			cfg_q.backoff_ms[2] <= rbrt_pkg::RST_BACKOFF_THIRD;
			cfg_q.backoff_ms[3] <= rbrt_pkg::RST_BACKOFF_LAST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbrt_pkg::REG_REPORT_INTERVAL: cfg_q.interval_ms <= interval_scaled;
				rbrt_pkg::REG_FIRST_DELAY:
					cfg_q.first_delay_ms <= cfg_data[rbrt_pkg::FIRST_W-1:0];
				rbrt_pkg::REG_BACKOFF_FIRST: cfg_q.backoff_ms[0] <= cfg_data;
				rbrt_pkg::REG_BACKOFF_SECOND: cfg_q.backoff_ms[1] <= cfg_data;
				rbrt_pkg::REG_BACKOFF_THIRD: cfg_q.backoff_ms[2] <= cfg_data;
				rbrt_pkg::REG_BACKOFF_LAST: cfg_q.backoff_ms[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/rbrt_core.sv
// Link state, backoff step, deadlines and the per-event update logic.
// Produces the start, report and link-up flags for the event in the input register.
// Depends on rbrt_pkg.
`timescale 1ns / 1ps

module rbrt_core #(
	parameter int TIME_BITS = rbrt_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [rbrt_pkg::CMD_W-1:0] command,
	input  logic [rbrt_pkg::NOW_W-1:0] now_ms,
	input  rbrt_pkg::rbrt_cfg_t cfg,
	output logic start_connect,
	output logic send_report,
	output logic link_up
);

	localparam int WIDE_W = (TIME_BITS > rbrt_pkg::DELAY_W) ? TIME_BITS : rbrt_pkg::DELAY_W;
	localparam int CMP_W = (TIME_BITS > rbrt_pkg::INTERVAL_W) ? TIME_BITS
		: rbrt_pkg::INTERVAL_W;

	logic connected_q, connected_n;
	logic [rbrt_pkg::IDX_W-1:0] idx_q, idx_n;
	logic [TIME_BITS-1:0] reconnect_dl_q, reconnect_dl_n;
	logic pending_q, pending_n;
	logic [TIME_BITS-1:0] last_report_q, last_report_n;
	logic [TIME_BITS-1:0] first_dl_q, first_dl_n;

	logic [WIDE_W-1:0] now_wide;
	logic [TIME_BITS-1:0] now_t;
	logic [WIDE_W-1:0] sched_sum;
	logic [WIDE_W-1:0] first_sum;
	logic [TIME_BITS-1:0] elapsed;
	logic [rbrt_pkg::IDX_W-1:0] idx_inc;
	logic interval_done;

	assign now_wide = WIDE_W'(now_ms);
	assign now_t = now_wide[TIME_BITS-1:0];
	assign sched_sum = WIDE_W'(now_t) + WIDE_W'(cfg.backoff_ms[idx_q]);
	assign first_sum = WIDE_W'(now_t) + WIDE_W'(cfg.first_delay_ms);
	assign elapsed = now_t - last_report_q;
	assign interval_done = CMP_W'(elapsed) >= CMP_W'(cfg.interval_ms);
	assign idx_inc = (idx_q == rbrt_pkg::IDX_W'(rbrt_pkg::STEPS - 1)) ? idx_q
		: idx_q + rbrt_pkg::IDX_W'(1);

	always_comb begin
		connected_n = connected_q;
		idx_n = idx_q;
		reconnect_dl_n = reconnect_dl_q;
		pending_n = pending_q;
		last_report_n = last_report_q;
		first_dl_n = first_dl_q;
		start_connect = 1'b0;
		send_report = 1'b0;
		unique case (command)
			rbrt_pkg::CMD_TICK: begin
				if (!connected_q) begin
					if (reconnect_dl_q == '0 || now_t >= reconnect_dl_q) begin
						start_connect = 1'b1;
						reconnect_dl_n = sched_sum[TIME_BITS-1:0];
						idx_n = idx_inc;
					end
				end else if (first_dl_q != '0 && now_t >= first_dl_q) begin
					send_report = 1'b1;
					last_report_n = now_t;
					first_dl_n = '0;
					pending_n = 1'b0;
				end else if (pending_q || interval_done) begin
					send_report = 1'b1;
					pending_n = 1'b0;
					last_report_n = now_t;
				end
			end
			rbrt_pkg::CMD_LINK_UP: begin
				connected_n = 1'b1;
				idx_n = '0;
				reconnect_dl_n = '0;
				pending_n = 1'b0;
				first_dl_n = first_sum[TIME_BITS-1:0];
			end
			rbrt_pkg::CMD_LINK_DOWN: begin
				connected_n = 1'b0;
				first_dl_n = '0;
				reconnect_dl_n = sched_sum[TIME_BITS-1:0];
				idx_n = idx_inc;
			end
			rbrt_pkg::CMD_REPORT_REQ: begin
				pending_n = 1'b1;
			end
		endcase
	end

	assign link_up = connected_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			idx_q <= '0;
			reconnect_dl_q <= '0;
			pending_q <= 1'b1;
			last_report_q <= '0;
			first_dl_q <= '0;
		end else if (step) begin
			connected_q <= connected_n;
			idx_q <= idx_n;
			reconnect_dl_q <= reconnect_dl_n;
			pending_q <= pending_n;
			last_report_q <= last_report_n;
			first_dl_q <= first_dl_n;
		end
	end

endmodule

FILE: tb/link_supervisor_checker.sv
// Checker for the reconnect backoff and report timer: watches the event, result and
// register-write ports, predicts every result beat and compares it with the block's output.
// Depends on rbrt_pkg.
`timescale 1ns / 1ps

module link_supervisor_checker
	import rbrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int error_count,
	output int pending
);

	typedef struct packed {
		logic start_connect;
		logic send_report;
		logic link_up;
	} link_result_t;

	logic [SEC_W-1:0] interval_sec;
	logic [FIRST_W-1:0] first_delay;
	logic [DELAY_W-1:0] backoff_delay [STEPS];

	logic connected;
	logic [IDX_W-1:0] backoff_step;
	logic [NOW_W-1:0] reconnect_at;
	logic report_owed;
	logic [NOW_W-1:0] last_report_ms;
	logic [NOW_W-1:0] first_report_at;

	link_result_t expected_results [$];

	function automatic void schedule_retry(input logic [NOW_W-1:0] now);
		reconnect_at = now + backoff_delay[backoff_step];
		if (backoff_step != IDX_W'(STEPS - 1)) begin
			backoff_step = backoff_step + 1'b1;
		end
	endfunction

	function automatic link_result_t step_link_supervisor(input logic [CMD_W-1:0] cmd,
			input logic [NOW_W-1:0] now);
		link_result_t r;
		logic [NOW_W-1:0] interval;
		logic [NOW_W-1:0] elapsed;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (!connected) begin
					if (reconnect_at == '0 || now >= reconnect_at) begin
						r.start_connect = 1'b1;
						schedule_retry(now);
					end
				end else if (first_report_at != '0 && now >= first_report_at) begin
					r.send_report = 1'b1;
					last_report_ms = now;
					first_report_at = '0;
					report_owed = 1'b0;
				end else begin
					interval = NOW_W'(interval_sec) * NOW_W'(1000);
					elapsed = now - last_report_ms;
					if (report_owed || elapsed >= interval) begin
						r.send_report = 1'b1;
						report_owed = 1'b0;
						last_report_ms = now;
					end
				end
			end
			CMD_LINK_UP: begin
				connected = 1'b1;
				backoff_step = '0;
				reconnect_at = '0;
				report_owed = 1'b0;
				first_report_at = now + NOW_W'(first_delay);
			end
			CMD_LINK_DOWN: begin
				connected = 1'b0;
				first_report_at = '0;
				schedule_retry(now);
			end
			default: begin
				report_owed = 1'b1;
			end
		endcase
		r.link_up = connected;
		return r;
	endfunction

	function automatic void note_mismatch(input string what);
		if (error_count < 10) begin
			$display("%0t ns: result mismatch: %s", $time, what);
		end
		error_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		link_result_t seen;
		link_result_t want;
		if (!arst_n) begin
			interval_sec = SEC_W'(60);
			first_delay = RST_FIRST_DELAY;
			backoff_delay[0] = RST_BACKOFF_FIRST;
			backoff_delay[1] = RST_BACKOFF_SECOND;
			backoff_delay[2] = RST_BACKOFF_THIRD;
			backoff_delay[3] = RST_BACKOFF_LAST;
			connected = 1'b0;
			backoff_step = '0;
			reconnect_at = '0;
			report_owed = 1'b1;
			last_report_ms = '0;
			first_report_at = '0;
			expected_results.delete();
			error_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REPORT_INTERVAL: interval_sec = cfg_data[SEC_W-1:0];
					REG_FIRST_DELAY: first_delay = cfg_data[FIRST_W-1:0];
					REG_BACKOFF_FIRST: backoff_delay[0] = cfg_data[DELAY_W-1:0];
					REG_BACKOFF_SECOND: backoff_delay[1] = cfg_data[DELAY_W-1:0];
					REG_BACKOFF_THIRD: backoff_delay[2] = cfg_data[DELAY_W-1:0];
					REG_BACKOFF_LAST: backoff_delay[3] = cfg_data[DELAY_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				seen.start_connect = m_tdata[0];
				seen.send_report = m_tdata[1];
				seen.link_up = m_tdata[2];
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("beat with nothing expected, start=%0b report=%0b up=%0b",
						seen.start_connect, seen.send_report, seen.link_up));
				end else begin
					want = expected_results.pop_front();
					if (want != seen) begin
						note_mismatch($sformatf(
							"expected start=%0b report=%0b up=%0b, got start=%0b report=%0b up=%0b",
							want.start_connect, want.send_report, want.link_up,
							seen.start_connect, seen.send_report, seen.link_up));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(step_link_supervisor(s_tdata[CMD_W-1:0],
					s_tdata[CMD_W +: NOW_W]));
			end
			pending <= expected_results.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Top of the reconnect backoff and report timer testbench: clock, reset, event stimulus,
// result back-pressure and register writes, with the verdict at the end.
// Depends on rbrt_pkg, reconnect_backoff_report_timer_top and link_supervisor_checker.
`timescale 1ns / 1ps

module tb_top;
	import rbrt_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [SEC_W-1:0] interval_sec;
		logic [FIRST_W-1:0] first_delay;
		logic [STEPS-1:0][DELAY_W-1:0] backoff;
	} timing_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int error_count;
	int pending;
	int cycle_count = 0;
	bit hold_req = 1'b0;
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;
	timing_t timing;
	logic [NOW_W-1:0] clock_ms;

	reconnect_backoff_report_timer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	link_supervisor_checker supervisor_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.error_count(error_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("reconnect_backoff_report_timer_top regression: fail");
			$finish;
		end
	end

	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now);
		int gap;
		if ($urandom_range(0, 15) == 0) begin
			sender_burst = !sender_burst;
		end
		gap = sender_burst ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({now, cmd});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
	endtask

	task automatic apply_timing(input timing_t t);
		write_reg(REG_REPORT_INTERVAL, {16'($urandom), t.interval_sec});
		write_reg(REG_FIRST_DELAY, {16'($urandom), t.first_delay});
		write_reg(REG_BACKOFF_FIRST, t.backoff[0]);
		write_reg(REG_BACKOFF_SECOND, t.backoff[1]);
		write_reg(REG_BACKOFF_THIRD, t.backoff[2]);
		write_reg(REG_BACKOFF_LAST, t.backoff[3]);
		@(negedge clk);
		cfg_we <= 1'b0;
		timing = t;
	endtask

	function automatic timing_t reset_timing();
		timing_t t;
		t.interval_sec = SEC_W'(60);
		t.first_delay = RST_FIRST_DELAY;
		t.backoff[0] = RST_BACKOFF_FIRST;
		t.backoff[1] = RST_BACKOFF_SECOND;
		t.backoff[2] = RST_BACKOFF_THIRD;
		t.backoff[3] = RST_BACKOFF_LAST;
		return t;
	endfunction

	function automatic timing_t pick_timing(input int phase);
		timing_t t;
		case (phase)
			0, PHASES - 1: t = reset_timing();
			1: t = '0;
			2: t = '1;
			default: begin
				t.interval_sec = SEC_W'($urandom_range(0, 4));
				t.first_delay = ($urandom_range(0, 3) == 0) ? FIRST_W'($urandom)
					: FIRST_W'($urandom_range(0, 3000));
				for (int k = 0; k < STEPS; k++) begin
					t.backoff[IDX_W'(k)] = ($urandom_range(0, 5) == 0) ? DELAY_W'($urandom)
						: DELAY_W'($urandom_range(0, 12000));
				end
			end
		endcase
		return t;
	endfunction

	function automatic logic [NOW_W-1:0] next_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3: return NOW_W'($urandom_range(1, 400));
			4, 5: return NOW_W'($urandom_range(0, 4000));
			6: return timing.backoff[IDX_W'($urandom_range(0, 3))]
				+ NOW_W'($urandom_range(0, 2)) - 1'b1;
			7: return NOW_W'(timing.interval_sec) * NOW_W'(1000)
				+ NOW_W'($urandom_range(0, 2)) - 1'b1;
			8: return NOW_W'(timing.first_delay) + NOW_W'($urandom_range(0, 2)) - 1'b1;
			default: return NOW_W'($urandom);
		endcase
	endfunction

	task automatic random_event();
		int r;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 58) begin
			cmd = CMD_TICK;
		end else if (r < 70) begin
			cmd = CMD_LINK_UP;
		end else if (r < 84) begin
			cmd = CMD_LINK_DOWN;
		end else begin
			cmd = CMD_REPORT_REQ;
		end
		if ($urandom_range(0, 9) == 0) begin
			send_event(cmd, NOW_W'($urandom));
		end else begin
			clock_ms = clock_ms + next_step();
			send_event(cmd, clock_ms);
		end
	endtask

	initial begin
		int w;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_req = 1'b0;
			end
			if ($urandom_range(0, 15) == 0) begin
				receiver_burst = !receiver_burst;
			end
			w = receiver_burst ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		timing = reset_timing();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Backoff walk from reset, saturating at the last step.
		send_event(CMD_TICK, 32'd0);
		send_event(CMD_TICK, 32'd4999);
		send_event(CMD_TICK, 32'd5000);
		send_event(CMD_TICK, 32'd15000);
		send_event(CMD_TICK, 32'd35000);
		send_event(CMD_TICK, 32'd65000);
		send_event(CMD_REPORT_REQ, 32'd70000);
		send_event(CMD_TICK, 32'd80000);
		// Link up twice, then the interval, first-report and request paths.
		send_event(CMD_LINK_UP, 32'd100000);
		send_event(CMD_LINK_UP, 32'd100010);
		send_event(CMD_TICK, 32'd100020);
		send_event(CMD_TICK, 32'd101510);
		send_event(CMD_TICK, 32'd101511);
		send_event(CMD_REPORT_REQ, 32'd101600);
		send_event(CMD_TICK, 32'd101700);
		send_event(CMD_TICK, 32'd161700);
		// Deadlines that wrap past the top of the time range.
		send_event(CMD_LINK_DOWN, 32'hFFFF_EC78);
		send_event(CMD_LINK_DOWN, 32'hFFFF_FFF0);
		send_event(CMD_TICK, 32'd5);
		send_event(CMD_TICK, 32'hFFFF_FFFF);
		send_event(CMD_LINK_UP, 32'hFFFF_FF00);
		send_event(CMD_TICK, 32'hFFFF_FFFE);
		send_event(CMD_TICK, 32'd100);
		send_event(CMD_REPORT_REQ, 32'd200);
		send_event(CMD_TICK, 32'd300);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			apply_timing(pick_timing(phase));
			clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + NOW_W'($urandom_range(0, 60000))
				: NOW_W'($urandom_range(0, 1000000));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					if (phase == 2 || phase == 6) begin
						hold_req = 1'b1;
					end else if (phase == 5) begin
						settle();
					end
				end
				random_event();
			end
		end

		settle();
		if (error_count == 0 && pending == 0) begin
			$display("reconnect_backoff_report_timer_top regression: pass");
		end else begin
			$display("reconnect_backoff_report_timer_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: reconnect_backoff_report_timer_top.f
sv/rbrt_pkg.sv
sv/rbrt_cfg.sv
sv/rbrt_core.sv
sv/reconnect_backoff_report_timer_top.sv
tb/link_supervisor_checker.sv
tb/tb_top.sv
